>>> sv/spq_pkg.sv
// spq_pkg: shared types, constants and operation codes for the sorted priority queue
// no dependencies; compiled before every other file of the block
package spq_pkg;

    localparam int CAPACITY      = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int COUNT_W       = $clog2(CAPACITY + 1);

    localparam int KIND_W     = 3;
    localparam int PRIO_REQ_W = 8;
    localparam int KEY_W      = 16;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 5;

    typedef logic [PRIORITY_BITS-1:0] prio_t;
    typedef logic [KEY_W-1:0]         key_t;
    typedef logic [COUNT_W-1:0]       count_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_SORTED    = 3'd0,
        KIND_PUSH_FRONT = 3'd1,
        KIND_PUSH_BACK = 3'd2,
        KIND_POP_FRONT = 3'd3,
        KIND_POP_BACK  = 3'd4,
        KIND_REMOVE    = 3'd5
    } kind_e;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        prio_t prio;
        key_t  key;
    } entry_t;

    // operation broadcast to every cell of the row
    typedef struct packed {
        logic   write;
        kind_e  kind;
        entry_t new_entry;
    } cell_op_t;

endpackage

>>> sv/spq_if.sv
// spq_in_if / spq_out_if: valid-ready channels for request and result words
// depends on spq_pkg for field widths
interface spq_in_if import spq_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [KIND_W-1:0]     kind;
    logic [PRIO_REQ_W-1:0] priority_req;
    logic [KEY_W-1:0]      key;

    modport source (output valid, output kind, output priority_req, output key, input ready);
    modport sink   (input valid, input kind, input priority_req, input key, output ready);
endinterface

interface spq_out_if import spq_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [PRIO_REQ_W-1:0] removed_priority;
    logic [OCC_W-1:0]      occupancy;

    modport source (output valid, output status, output removed_priority, output occupancy,
                    input ready);
    modport sink   (input valid, input status, input removed_priority, input occupancy,
                    output ready);
endinterface

>>> sv/spq_cell.sv
// spq_cell: one slot of the queue; holds an entry and shifts to or from its neighbors
// depends on spq_pkg
module spq_cell import spq_pkg::*;
(
    input  logic     clk,
    input  cell_op_t op,
    input  logic     in_use,
    input  logic     is_last,
    input  entry_t   left_entry,
    input  entry_t   right_entry,
    input  logic     hit_in,
    input  prio_t    found_in,
    output entry_t   entry,
    output logic     hit_out,
    output prio_t    found_out
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   hit_local;

    assign entry = entry_reg;

    always_comb
    begin
        unique case (op.kind)
            KIND_SORTED:     hit_local = !in_use || (entry_reg.prio > op.new_entry.prio);
            KIND_PUSH_FRONT: hit_local = 1'b1;
            KIND_PUSH_BACK:  hit_local = !in_use;
            KIND_POP_FRONT:  hit_local = in_use;
            KIND_POP_BACK:   hit_local = is_last;
            KIND_REMOVE:     hit_local = in_use && (entry_reg.key == op.new_entry.key);
            default:         hit_local = 1'b0;
        endcase
    end

    // first hit from the head decides the insert or removal position
    assign hit_out   = hit_in | hit_local;
    assign found_out = hit_in ? found_in : (hit_local ? entry_reg.prio : '0);

    always_comb
    begin
        entry_next = entry_reg;
        case (op.kind) inside
            KIND_SORTED, KIND_PUSH_FRONT, KIND_PUSH_BACK:
            begin
                if (hit_in)
                    entry_next = left_entry;
                else if (hit_local)
                    entry_next = op.new_entry;
            end
            KIND_POP_FRONT, KIND_REMOVE:
            begin
                if (hit_out)
                    entry_next = right_entry;
            end
            default: entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (op.write)
            entry_reg <= entry_next;
    end

endmodule

>>> sv/sorted_priority_queue_core.sv
// sorted_priority_queue_core: bounded ordered queue of (priority, key) entries
// depends on spq_pkg, spq_if.sv and spq_cell
//
// usage:
//   req carries one operation word (kind, priority_req, key); rsp returns one
//   result word (status, removed_priority, occupancy) for every request.
//   the entries live in a row of CAPACITY cells; each operation is broadcast to
//   the row and the insert or removal position ripples from head to tail, so
//   every cell shifts toward or away from its neighbor in the same cycle.
//   the result is registered and appears in the cycle after the request is taken.
//   throughput: one word per cycle while rsp is taken; the position ripple along
//   the row of cells is combinational.
//   req.ready is high while the result register is empty or being drained, so
//   a stalled receiver holds one result and stops further requests.
//   reset clears the entry count and the result valid flag; entry contents are
//   left as they are and are never read before being written.
module sorted_priority_queue_core import spq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    spq_in_if.sink    req,
    spq_out_if.source rsp
);

    cell_op_t op;
    logic     accept;
    logic     is_insert;
    logic     is_removal;
    logic     full;

    count_t count_reg;
    count_t count_next;

    logic                  rsp_valid_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;
    logic [PRIO_REQ_W-1:0] removed_reg;
    logic [PRIO_REQ_W-1:0] removed_next;

    entry_t cell_entry  [CAPACITY];
    logic   hit_chain   [CAPACITY+1];
    prio_t  found_chain [CAPACITY+1];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign is_insert  = (req.kind == KIND_SORTED) || (req.kind == KIND_PUSH_FRONT)
                     || (req.kind == KIND_PUSH_BACK);
    assign is_removal = (req.kind == KIND_POP_FRONT) || (req.kind == KIND_POP_BACK)
                     || (req.kind == KIND_REMOVE);
    assign full       = (count_reg == COUNT_W'(CAPACITY));

    assign op.write          = accept && !(is_insert && full);
    assign op.kind           = kind_e'(req.kind);
    assign op.new_entry.prio = prio_t'(req.priority_req);
    assign op.new_entry.key  = req.key;

    assign hit_chain[0]   = 1'b0;
    assign found_chain[0] = '0;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            localparam count_t IDX     = COUNT_W'(i);
            localparam count_t IDX_END = COUNT_W'(i + 1);
            entry_t left_entry;
            entry_t right_entry;

            if (i == 0)
            begin : g_head
                assign left_entry = '0;
            end
            else
            begin : g_mid_l
                assign left_entry = cell_entry[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign right_entry = '0;
            end
            else
            begin : g_mid_r
                assign right_entry = cell_entry[i+1];
            end

            spq_cell u_cell
            (
                .clk         (clk),
                .op          (op),
                .in_use      (IDX < count_reg),
                .is_last     (count_reg == IDX_END),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .hit_in      (hit_chain[i]),
                .found_in    (found_chain[i]),
                .entry       (cell_entry[i]),
                .hit_out     (hit_chain[i+1]),
                .found_out   (found_chain[i+1])
            );
        end
    endgenerate

    always_comb
    begin
        count_next   = count_reg;
        status_next  = ST_DONE;
        removed_next = '0;
        if (is_insert)
        begin
            if (full)
                status_next = ST_FULL;
            else
                count_next = count_reg + 1'b1;
        end
        else if (is_removal)
        begin
            // a hit anywhere in the row means an entry was found and removed
            if (hit_chain[CAPACITY])
            begin
                count_next   = count_reg - 1'b1;
                removed_next = PRIO_REQ_W'(found_chain[CAPACITY]);
            end
            else
                status_next = ST_MISS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                count_reg <= count_next;
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
        end
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.status           = status_reg;
    assign rsp.removed_priority = removed_reg;
    assign rsp.occupancy        = OCC_W'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("accepted word produced no result");

    a_full_only_at_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && status_reg == ST_FULL) |-> full)
        else $error("full status while queue not at capacity");

    a_miss_no_priority: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && status_reg != ST_DONE) |-> (removed_reg == '0))
        else $error("removed priority reported without a removal");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("entry count changed without an accepted word");

endmodule
